>>> rtl/core/cfe_pkg.sv
// ----------------------------------------------------------------------------
// cfe_pkg
// shared constants and types of the cuckoo filter engine
// ----------------------------------------------------------------------------
`default_nettype none

package cfe_pkg;

   // filter geometry (bucket count is a power of two)
   localparam int BUCKETS     = 1024;
   localparam int WAYS        = 4;
   localparam int FP_BITS     = 8;
   localparam int BUCKET_BITS = $clog2(BUCKETS);
   localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WORD_BITS   = WAYS * FP_BITS;

   // request fields
   localparam int MODE_BITS = 2;
   localparam int KEY_BITS  = 64;
   localparam int FP_LSB    = 32;

   localparam logic [MODE_BITS-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_DELETE = 2'd2;

   // alternate bucket hash multiplier and victim lfsr seed
   localparam logic [31:0] ALT_MULT  = 32'h5bd1_e995;
   localparam logic [15:0] LFSR_SEED = 16'hACE1;

   // register file
   localparam int LOG2_BITS      = 4;
   localparam int KICK_BITS      = 10;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 10;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BUCKET_LOG2 = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_KICKS   = 2'd1;

   localparam logic [LOG2_BITS-1:0] BUCKET_LOG2_RESET = 4'd10;
   localparam logic [KICK_BITS-1:0] MAX_KICKS_RESET   = 10'd256;

   typedef struct packed {
      logic [LOG2_BITS-1:0] bucket_log2;
      logic [KICK_BITS-1:0] max_kicks;
   } cfg_type;

   typedef struct packed {
      logic                found;
      logic [WAY_BITS-1:0] slot;
   } slot_find_type;

endpackage

`default_nettype wire

>>> rtl/core/cfe_ram.sv
// ----------------------------------------------------------------------------
// cfe_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module cfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       we,
   input  wire logic [$clog2(DEPTH)-1:0]   waddr,
   input  wire logic [WIDTH-1:0]           wdata,
   input  wire logic [$clog2(DEPTH)-1:0]   raddr,
   output logic      [WIDTH-1:0]           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/core/cfe_csr.sv
// ----------------------------------------------------------------------------
// cfe_csr
// configuration registers: bucket count and kick limit
// ----------------------------------------------------------------------------
`default_nettype none

module cfe_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [cfe_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [cfe_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output cfe_pkg::cfg_type                         cfg
);

   cfe_pkg::cfg_type cfg_ff;
   cfe_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cfe_pkg::CSR_BUCKET_LOG2: begin
               cfg_in.bucket_log2 = csr_wdata[cfe_pkg::LOG2_BITS-1:0];
            end
            cfe_pkg::CSR_MAX_KICKS: begin
               cfg_in.max_kicks = csr_wdata[cfe_pkg::KICK_BITS-1:0];
            end
            default: begin
               // writes beyond the register list are dropped
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bucket_log2 <= cfe_pkg::BUCKET_LOG2_RESET;
         cfg_ff.max_kicks   <= cfe_pkg::MAX_KICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/core/cfe_ctrl.sv
// ----------------------------------------------------------------------------
// cfe_ctrl
// sequencer: bucket reads, slot search, updates and the eviction loop
// ----------------------------------------------------------------------------
`default_nettype none

module cfe_ctrl (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire cfe_pkg::cfg_type                     cfg,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [cfe_pkg::MODE_BITS-1:0]        req_mode,
   input  wire logic [cfe_pkg::KEY_BITS-1:0]         req_key_hash,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_status,
   output logic                                      mem_we,
   output logic      [cfe_pkg::BUCKET_BITS-1:0]      mem_waddr,
   output logic      [cfe_pkg::WORD_BITS-1:0]        mem_wdata,
   output logic      [cfe_pkg::BUCKET_BITS-1:0]      mem_raddr,
   input  wire logic [cfe_pkg::WORD_BITS-1:0]        mem_rdata
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD0,
      ST_RD1,
      ST_KICK_RD,
      ST_KICK_CHK,
      ST_RESP
   } state_type;

   typedef logic [cfe_pkg::BUCKET_BITS-1:0] bucket_type;
   typedef logic [cfe_pkg::FP_BITS-1:0]     fp_type;
   typedef logic [cfe_pkg::WORD_BITS-1:0]   word_type;
   typedef logic [cfe_pkg::WAY_BITS-1:0]    way_type;

   function automatic cfe_pkg::slot_find_type find_fp(word_type w, fp_type fp);
      cfe_pkg::slot_find_type r;
      r = '0;
      for (int s = cfe_pkg::WAYS - 1; s >= 0; s--) begin
         if (w[s*cfe_pkg::FP_BITS +: cfe_pkg::FP_BITS] == fp) begin
            r.found = 1'b1;
            r.slot  = way_type'(s);
         end
      end
      return r;
   endfunction

   function automatic fp_type get_slot(word_type w, way_type s);
      return w[s*cfe_pkg::FP_BITS +: cfe_pkg::FP_BITS];
   endfunction

   function automatic word_type set_slot(word_type w, way_type s, fp_type v);
      word_type r;
      r = w;
      r[s*cfe_pkg::FP_BITS +: cfe_pkg::FP_BITS] = v;
      return r;
   endfunction

   function automatic bucket_type alt_bucket(bucket_type b, fp_type fp, bucket_type mask);
      bucket_type p;
      p = bucket_type'(fp) * bucket_type'(cfe_pkg::ALT_MULT);
      return (b ^ p) & mask;
   endfunction

   state_type                              state_ff, state_in;
   logic [cfe_pkg::MODE_BITS-1:0]          mode_ff, mode_in;
   fp_type                                 fp_ff, fp_in;
   fp_type                                 hand_ff, hand_in;
   bucket_type                             b0_ff, b0_in;
   bucket_type                             b1_ff, b1_in;
   bucket_type                             dst_ff, dst_in;
   bucket_type                             clr_addr_ff, clr_addr_in;
   word_type                               b0_word_ff, b0_word_in;
   logic [cfe_pkg::KICK_BITS-1:0]          kick_cnt_ff, kick_cnt_in;
   logic [15:0]                            lfsr_ff, lfsr_in;
   logic                                   status_ff, status_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic                                   rsp_status_ff, rsp_status_in;

   bucket_type                             bucket_mask;
   fp_type                                 req_fp;
   bucket_type                             req_b0;
   bucket_type                             req_b1;
   logic [15:0]                            lfsr_next;
   way_type                                victim;
   fp_type                                 evicted;
   cfe_pkg::slot_find_type                 hit0, hit1, free0, free1, free_k;

   // mask of bucket index bits in use
   always_comb begin
      for (int i = 0; i < cfe_pkg::BUCKET_BITS; i++) begin
         bucket_mask[i] = (i < int'(cfg.bucket_log2));
      end
   end

   // request decode: fingerprint (zero means empty slot) and both buckets
   always_comb begin
      req_fp = req_key_hash[cfe_pkg::FP_LSB +: cfe_pkg::FP_BITS];
      if (req_fp == '0) begin
         req_fp = fp_type'(1);
      end
      req_b0 = req_key_hash[cfe_pkg::BUCKET_BITS-1:0] & bucket_mask;
      req_b1 = alt_bucket(req_b0, req_fp, bucket_mask);
   end

   // fibonacci lfsr, taps 16 14 13 11
   assign lfsr_next = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5], lfsr_ff[15:1]};
   assign victim    = way_type'(lfsr_next % cfe_pkg::WAYS);

   assign hit0   = find_fp(b0_word_ff, fp_ff);
   assign hit1   = find_fp(mem_rdata, fp_ff);
   assign free0  = find_fp(b0_word_ff, '0);
   assign free1  = find_fp(mem_rdata, '0);
   assign free_k = find_fp(mem_rdata, '0);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      fp_in         = fp_ff;
      hand_in       = hand_ff;
      b0_in         = b0_ff;
      b1_in         = b1_ff;
      dst_in        = dst_ff;
      clr_addr_in   = clr_addr_ff;
      b0_word_in    = b0_word_ff;
      kick_cnt_in   = kick_cnt_ff;
      lfsr_in       = lfsr_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      evicted       = '0;
      mem_we        = 1'b0;
      mem_waddr     = b0_ff;
      mem_wdata     = b0_word_ff;
      mem_raddr     = b0_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + bucket_type'(1);
            if (clr_addr_ff == bucket_type'(cfe_pkg::BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            mem_raddr = req_b0;
            if (req_valid) begin
               mode_in  = req_mode;
               fp_in    = req_fp;
               b0_in    = req_b0;
               b1_in    = req_b1;
               state_in = ST_RD0;
            end
         end
         ST_RD0: begin
            b0_word_in = mem_rdata;
            mem_raddr  = b1_ff;
            state_in   = ST_RD1;
         end
         ST_RD1: begin
            // primary word is registered, alternate word is on the read port
            state_in  = ST_RESP;
            status_in = 1'b1;
            unique case (mode_ff)
               cfe_pkg::MODE_LOOKUP: begin
                  status_in = !(hit0.found || hit1.found);
               end
               cfe_pkg::MODE_DELETE: begin
                  if (hit0.found) begin
                     mem_we    = 1'b1;
                     mem_waddr = b0_ff;
                     mem_wdata = set_slot(b0_word_ff, hit0.slot, '0);
                     status_in = 1'b0;
                  end else if (hit1.found) begin
                     mem_we    = 1'b1;
                     mem_waddr = b1_ff;
                     mem_wdata = set_slot(mem_rdata, hit1.slot, '0);
                     status_in = 1'b0;
                  end
               end
               cfe_pkg::MODE_INSERT: begin
                  if (free0.found) begin
                     mem_we    = 1'b1;
                     mem_waddr = b0_ff;
                     mem_wdata = set_slot(b0_word_ff, free0.slot, fp_ff);
                     status_in = 1'b0;
                  end else if (free1.found) begin
                     mem_we    = 1'b1;
                     mem_waddr = b1_ff;
                     mem_wdata = set_slot(mem_rdata, free1.slot, fp_ff);
                     status_in = 1'b0;
                  end else begin
                     // both full: evict from the primary bucket
                     lfsr_in     = lfsr_next;
                     evicted     = get_slot(b0_word_ff, victim);
                     hand_in     = evicted;
                     mem_we      = 1'b1;
                     mem_waddr   = b0_ff;
                     mem_wdata   = set_slot(b0_word_ff, victim, fp_ff);
                     dst_in      = alt_bucket(b0_ff, evicted, bucket_mask);
                     kick_cnt_in = '0;
                     state_in    = ST_KICK_RD;
                  end
               end
               default: begin
                  status_in = 1'b1;
               end
            endcase
         end
         ST_KICK_RD: begin
            // read issued after the previous write has landed
            mem_raddr = dst_ff;
            state_in  = ST_KICK_CHK;
         end
         ST_KICK_CHK: begin
            if (free_k.found) begin
               mem_we    = 1'b1;
               mem_waddr = dst_ff;
               mem_wdata = set_slot(mem_rdata, free_k.slot, hand_ff);
               status_in = 1'b0;
               state_in  = ST_RESP;
            end else if (kick_cnt_ff >= cfg.max_kicks) begin
               // fingerprint in hand is dropped
               status_in = 1'b1;
               state_in  = ST_RESP;
            end else begin
               lfsr_in     = lfsr_next;
               evicted     = get_slot(mem_rdata, victim);
               hand_in     = evicted;
               mem_we      = 1'b1;
               mem_waddr   = dst_ff;
               mem_wdata   = set_slot(mem_rdata, victim, hand_ff);
               dst_in      = alt_bucket(dst_ff, evicted, bucket_mask);
               kick_cnt_in = kick_cnt_ff + cfe_pkg::KICK_BITS'(1);
               state_in    = ST_KICK_RD;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         lfsr_ff      <= cfe_pkg::LFSR_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      fp_ff         <= fp_in;
      hand_ff       <= hand_in;
      b0_ff         <= b0_in;
      b1_ff         <= b1_in;
      dst_ff        <= dst_in;
      b0_word_ff    <= b0_word_in;
      kick_cnt_ff   <= kick_cnt_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   a_clear_writes_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (mem_we && (mem_wdata == '0)))
      else $error("clearing pass must write an empty bucket every cycle");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_RD0 || state_ff == ST_KICK_RD ||
       state_ff == ST_RESP) |-> !mem_we)
      else $error("bucket write outside an update step");

   a_kick_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_KICK_CHK) |-> (kick_cnt_ff <= cfg.max_kicks))
      else $error("eviction loop ran past the kick limit");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result raised outside the response step");

endmodule

`default_nettype wire

>>> rtl/core/cuckoo_filter_engine.sv
// ----------------------------------------------------------------------------
// cuckoo_filter_engine
// cuckoo filter of 4-slot buckets holding 8-bit fingerprints
// ----------------------------------------------------------------------------
// usage
//  - req channel: one transfer carries a mode (lookup, insert, delete) and a
//    64-bit key hash; rsp channel returns exactly one status bit per request
//    (0 found / inserted / deleted, 1 absent / insert failed / unused mode)
//  - csr channel: register 0 bucket_count_log2, register 1 max_kicks;
//    always ready, write only while no request is in flight
//  - lookup, delete and inserts that find a free slot run the two bucket
//    reads, which the single read port of the bucket ram takes in turn, then
//    an update step and a response step
//  - an insert that evicts adds relocation rounds (read of the
//    alternate bucket, then search and write back), up to max_kicks + 1 rounds
//  - the result sits in an output register; a new request is taken while it
//    waits, and a stalled receiver holds the engine in its response step
//  - after reset the bucket ram is swept to empty, one bucket per cycle;
//    req_ready stays low during the sweep
// ----------------------------------------------------------------------------
`default_nettype none

module cuckoo_filter_engine (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [cfe_pkg::MODE_BITS-1:0]        req_mode,
   input  wire logic [cfe_pkg::KEY_BITS-1:0]         req_key_hash,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_status,
   // configuration write channel
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [cfe_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [cfe_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   cfe_pkg::cfg_type                      cfg;

   // bucket ram ports
   logic                                  mem_we;
   logic [cfe_pkg::BUCKET_BITS-1:0]       mem_waddr;
   logic [cfe_pkg::WORD_BITS-1:0]         mem_wdata;
   logic [cfe_pkg::BUCKET_BITS-1:0]       mem_raddr;
   logic [cfe_pkg::WORD_BITS-1:0]         mem_rdata;

   // register file
   cfe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: reads, slot search, eviction loop, response register
   cfe_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_key_hash (req_key_hash),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata)
   );

   // one word per bucket, slot 0 in the low bits
   cfe_ram #(
      .WIDTH (cfe_pkg::WORD_BITS),
      .DEPTH (cfe_pkg::BUCKETS)
   ) u_bucket_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

`default_nettype wire

>>> verif/tb_cuckoo_filter_engine.sv
// ----------------------------------------------------------------------------
// tb_cuckoo_filter_engine
// self-checking testbench of the cuckoo filter engine: a predictor keeps its
// own copy of the bucket store, victim lfsr and registers, works out the
// status of every accepted request and checks each response transfer in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cuckoo_filter_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import cfe_pkg::*;

   // codes the package leaves out: the spare mode and a register index
   // that maps to nothing
   localparam logic [MODE_BITS-1:0]      MODE_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED  = 2'd2;

   // cycles without any transfer before the run is abandoned: covers the
   // sweep after reset and a full 1024-round eviction chain
   localparam int WATCHDOG_LIMIT = 20000;
   // settling time after the last response
   localparam int DRAIN_CYCLES   = 40;
   localparam int KEY_POOL_DEPTH = 48;

   // -------------------------------------------------------------------------
   // scoreboard: filter predictor plus the queue of expected status bits
   // -------------------------------------------------------------------------
   class cuckoo_scoreboard;
      logic [FP_BITS-1:0]   slots [BUCKETS][WAYS];
      logic [15:0]          victim_lfsr;
      logic [LOG2_BITS-1:0] bucket_log2;
      logic [KICK_BITS-1:0] kick_limit;
      bit                   expected_status [$];
      int                   mismatches;
      int                   checked;
      int                   requests;
      int                   inserts;
      int                   evicting_inserts;
      int                   failed_inserts;

      function new();
         foreach (slots[b, s]) slots[b][s] = '0;
         victim_lfsr      = LFSR_SEED;
         bucket_log2      = BUCKET_LOG2_RESET;
         kick_limit       = MAX_KICKS_RESET;
         mismatches       = 0;
         checked          = 0;
         requests         = 0;
         inserts          = 0;
         evicting_inserts = 0;
         failed_inserts   = 0;
      endfunction

      task report_mismatch(input string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      function void write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                   input logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_BUCKET_LOG2: bucket_log2 = data[LOG2_BITS-1:0];
            CSR_MAX_KICKS:   kick_limit  = data[KICK_BITS-1:0];
            default: ;
         endcase
      endfunction

      // mask to the buckets in use, then wrap into the physical store
      function logic [BUCKET_BITS-1:0] bucket_index(input logic [63:0] v);
         logic [63:0] mask;
         mask = (64'd1 << bucket_log2) - 64'd1;
         return BUCKET_BITS'((v & mask) % BUCKETS);
      endfunction

      function logic [BUCKET_BITS-1:0] alt_index(input logic [BUCKET_BITS-1:0] b,
                                                 input logic [FP_BITS-1:0] fp);
         logic [63:0] scramble;
         scramble = 64'(fp) * 64'(ALT_MULT);
         return bucket_index(64'(b) ^ scramble);
      endfunction

      // fibonacci lfsr, taps 16,14,13,11; slot comes from the new value
      function int next_victim();
         logic feedback;
         feedback    = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5];
         victim_lfsr = {feedback, victim_lfsr[15:1]};
         return int'(victim_lfsr % WAYS);
      endfunction

      function bit fill_empty(input logic [BUCKET_BITS-1:0] b,
                              input logic [FP_BITS-1:0] fp);
         for (int s = 0; s < WAYS; s++) begin
            if (slots[b][s] == '0) begin
               slots[b][s] = fp;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function bit find_fp(input logic [BUCKET_BITS-1:0] b,
                           input logic [FP_BITS-1:0] fp, output int slot);
         slot = 0;
         for (int s = 0; s < WAYS; s++) begin
            if (slots[b][s] == fp) begin
               slot = s;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      // returns the status bit: 0 placed, 1 chain ran out of kicks
      function bit insert_fp(input logic [BUCKET_BITS-1:0] b0,
                             input logic [BUCKET_BITS-1:0] b1,
                             input logic [FP_BITS-1:0] fp);
         logic [FP_BITS-1:0]     hand;
         logic [FP_BITS-1:0]     swap;
         logic [BUCKET_BITS-1:0] dst;
         int                     k;
         int                     rounds;
         bit                     placed;
         if (fill_empty(b0, fp)) return 1'b0;
         if (fill_empty(b1, fp)) return 1'b0;
         evicting_inserts++;
         k           = next_victim();
         hand        = slots[b0][k];
         slots[b0][k] = fp;
         dst         = alt_index(b0, hand);
         rounds      = 0;
         placed      = 1'b0;
         while (!placed && rounds <= int'(kick_limit)) begin
            if (fill_empty(dst, hand)) begin
               placed = 1'b1;
            end else begin
               rounds++;
               if (rounds <= int'(kick_limit)) begin
                  k             = next_victim();
                  swap          = slots[dst][k];
                  slots[dst][k] = hand;
                  hand          = swap;
                  dst           = alt_index(dst, hand);
               end
            end
         end
         if (!placed) failed_inserts++;
         return !placed;
      endfunction

      function void note_request(input logic [MODE_BITS-1:0] mode,
                                 input logic [KEY_BITS-1:0] key);
         logic [FP_BITS-1:0]     fp;
         logic [BUCKET_BITS-1:0] b0;
         logic [BUCKET_BITS-1:0] b1;
         bit                     status;
         int                     s;
         fp = key[FP_LSB +: FP_BITS];
         if (fp == '0) fp = 1;
         b0     = bucket_index(key);
         b1     = alt_index(b0, fp);
         status = 1'b1;
         requests++;
         case (mode)
            MODE_LOOKUP: begin
               if (find_fp(b0, fp, s) || find_fp(b1, fp, s)) status = 1'b0;
            end
            MODE_INSERT: begin
               inserts++;
               status = insert_fp(b0, b1, fp);
            end
            MODE_DELETE: begin
               if (find_fp(b0, fp, s)) begin
                  slots[b0][s] = '0;
                  status       = 1'b0;
               end else if (find_fp(b1, fp, s)) begin
                  slots[b1][s] = '0;
                  status       = 1'b0;
               end
            end
            default: ;
         endcase
         expected_status.push_back(status);
      endfunction

      task check_response(input logic status);
         bit want;
         if (expected_status.size() == 0) begin
            report_mismatch($sformatf("response with status %0b but no request pending",
                                      status));
         end else begin
            want = expected_status.pop_front();
            checked++;
            if (status !== want)
               report_mismatch($sformatf("response %0d: status %0b, expected %0b",
                                         checked, status, want));
         end
      endtask

      task check_drained();
         if (expected_status.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived",
                                      expected_status.size()));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // signals
   // -------------------------------------------------------------------------
   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [MODE_BITS-1:0]      req_mode;
   logic [KEY_BITS-1:0]       req_key_hash;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_status;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   cuckoo_scoreboard filter_sb;
   logic [KEY_BITS-1:0] key_pool [$];   // recently inserted keys, for hits
   int send_idle_pct;                   // chance per cycle that the sender idles
   int rsp_stall_pct;                   // chance per cycle that the receiver stalls
   int quiet_cycles;
   int settings_used;

   cuckoo_filter_engine dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_key_hash (req_key_hash),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // receiver: ready is redrawn every cycle, so stalls land anywhere in the
   // response step, including while a response is already waiting
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // response check, values sampled as they stood at the edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) filter_sb.check_response(rsp_status);
   end

   // watchdog: any transfer on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles, %0d responses outstanding",
                  WATCHDOG_LIMIT, filter_sb.expected_status.size());
         $display("tb_cuckoo_filter_engine: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // drivers
   // -------------------------------------------------------------------------

   // one request transfer; valid is only dropped when an idle gap follows,
   // so back-to-back requests keep valid high without a glitch
   task automatic send_request(input logic [MODE_BITS-1:0] mode,
                               input logic [KEY_BITS-1:0] key);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < send_idle_pct);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_key_hash <= key;
      do begin
         @(posedge clock);
      end while (!req_ready);
      filter_sb.note_request(mode, key);
      if (mode == MODE_INSERT) begin
         key_pool.push_back(key);
         if (key_pool.size() > KEY_POOL_DEPTH) void'(key_pool.pop_front());
      end
   endtask

   // leaves csr_valid high; the caller drops it after its last write
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      filter_sb.write_register(index, data);
   endtask

   // stop sending and let every outstanding request complete
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (filter_sb.expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // upper data bits of the log2 register are junk the block must drop
   task automatic set_config(input int log2_value, input int kick_value);
      write_csr(CSR_BUCKET_LOG2, {6'($urandom), 4'(log2_value)});
      write_csr(CSR_MAX_KICKS, 10'(kick_value));
      if ($urandom_range(1) == 1) write_csr(CSR_UNUSED, 10'($urandom));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // half the keys come back from recent inserts with the bits that matter
   // (bucket field and fingerprint) kept and the rest scrambled
   function automatic logic [KEY_BITS-1:0] pick_key();
      logic [KEY_BITS-1:0] key;
      key = {$urandom, $urandom};
      if (key_pool.size() != 0 && $urandom_range(1) == 1) begin
         key        = key_pool[$urandom_range(key_pool.size() - 1)];
         key[63:40] = 24'($urandom);
         key[31:10] = 22'($urandom);
      end else if ($urandom_range(15) == 0) begin
         key[FP_LSB +: FP_BITS] = '0;
      end
      return key;
   endfunction

   function automatic logic [MODE_BITS-1:0] pick_mode();
      int r;
      r = $urandom_range(99);
      if (r < 45) return MODE_INSERT;
      if (r < 75) return MODE_LOOKUP;
      if (r < 95) return MODE_DELETE;
      return MODE_UNUSED;
   endfunction

   task automatic run_phase(input int log2_value, input int kick_value, input int count,
                            input int idle_pct, input int stall_pct);
      wait_idle();
      set_config(log2_value, kick_value);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_request(pick_mode(), pick_key());
   endtask

   // -------------------------------------------------------------------------
   // sequence
   // -------------------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_mode      = MODE_LOOKUP;
      req_key_hash  = '0;
      rsp_ready     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CSR_BUCKET_LOG2;
      csr_wdata     = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      quiet_cycles  = 0;
      settings_used = 1;
      filter_sb     = new();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset settings, no idling
      send_request(MODE_LOOKUP, 64'h0);                    // empty filter misses
      send_request(MODE_INSERT, 64'h0);                    // zero fingerprint stored as one
      send_request(MODE_LOOKUP, 64'h0);
      send_request(MODE_LOOKUP, 64'h1_0000_0000);          // fingerprint one aliases zero
      send_request(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);  // top bucket, all-ones fp
      send_request(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(MODE_DELETE, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(MODE_DELETE, 64'hFFFF_FFFF_FFFF_FFFF);  // already gone
      send_request(MODE_UNUSED, 64'h0);                    // spare mode touches nothing
      send_request(MODE_LOOKUP, 64'h0);
      // duplicates fill the primary bucket, then the alternate one
      repeat (7) send_request(MODE_INSERT, 64'h0);
      // key whose primary is the alternate above: both full, the chain
      // bounces between the two buckets until the kick limit is passed
      send_request(MODE_INSERT, 64'h1_0000_0195);
      send_request(MODE_LOOKUP, 64'h1_0000_0195);
      send_request(MODE_DELETE, 64'h0);                    // primary copy goes first
      send_request(MODE_INSERT, 64'h0000_0042_0000_0000);  // lands in the freed slot
      send_request(MODE_INSERT, 64'h5555_5555_AAAA_AAAA);
      send_request(MODE_LOOKUP, 64'hAAAA_AAAA_5555_5555);

      // random part: settings from one bucket up to beyond the store size,
      // kick limits from none to the maximum
      run_phase(10,   256, 150,  0,  0);
      run_phase( 3,     8, 200, 79,  0);
      run_phase( 0,     0, 150,  0, 79);
      run_phase(15,  1023, 150, 36, 36);
      run_phase( 2,  1023,  50,  0,  0);   // tiny and full: long failing chains
      run_phase(11,     3,  50, 79,  0);
      run_phase( 5,    31, 250, 36, 36);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      filter_sb.check_drained();

      $display("covered %0d requests over %0d register settings, %0d responses checked",
               filter_sb.requests, settings_used, filter_sb.checked);
      $display("%0d inserts, %0d needed evictions, %0d ran out of kicks",
               filter_sb.inserts, filter_sb.evicting_inserts, filter_sb.failed_inserts);
      if (filter_sb.mismatches == 0) begin
         $display("tb_cuckoo_filter_engine: PASS");
      end else begin
         $display("tb_cuckoo_filter_engine: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
